### src/scrc_pkg.sv
// scrc_pkg: shared constants, types and the crc-16 byte step for the sync frame checker
// no dependencies; compiled first
`default_nettype none

package scrc_pkg;

  localparam int BYTE_W    = 8;
  localparam int CRC_W     = 16;
  localparam int COUNT_W   = 7;
  localparam int CFG_IDX_W = 2;

  localparam int PAYLOAD_BYTES = 121;
  localparam logic [COUNT_W-1:0] PAYLOAD_COUNT = COUNT_W'(PAYLOAD_BYTES);

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hEA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h9B;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;

  typedef struct packed {
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [COUNT_W-1:0]  payload_index;
    logic                frame_end;
    logic                crc_ok;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [CRC_W-1:0]  seed;        // crc after init and the first sync byte
  } sync_cfg_t;

  // one byte through crc-16/ccitt-false, msb first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  localparam logic [CRC_W-1:0] SEED_RESET = crc_byte(CRC_INIT, SYNC_FIRST_RESET);

endpackage

`default_nettype wire

### src/scrc_in_if.sv
// scrc_in_if: received byte channel, one byte per transfer
// depends on scrc_pkg
`default_nettype none

interface scrc_in_if;
  logic                        valid;
  logic                        ready;
  logic [scrc_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/scrc_out_if.sv
// scrc_out_if: result channel, one result per received byte
// depends on scrc_pkg
`default_nettype none

interface scrc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         payload_valid;
  logic [scrc_pkg::BYTE_W-1:0]  payload_byte;
  logic [scrc_pkg::COUNT_W-1:0] payload_index;
  logic                         frame_end;
  logic                         crc_ok;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_end, output crc_ok, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input payload_index, input frame_end, input crc_ok, output ready);
endinterface

`default_nettype wire

### src/scrc_cfg_if.sv
// scrc_cfg_if: register write channel (index and data)
// depends on scrc_pkg
`default_nettype none

interface scrc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [scrc_pkg::CFG_IDX_W-1:0] reg_index;
  logic [scrc_pkg::BYTE_W-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

### src/scrc_deframer.sv
// scrc_deframer: sync hunt, payload count and running crc, one byte per transfer
// depends on scrc_pkg (types, constants, crc_byte)
`default_nettype none

module scrc_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        take,
  input  wire logic [scrc_pkg::BYTE_W-1:0] rx_byte,
  input  wire scrc_pkg::sync_cfg_t         cfg,
  output scrc_pkg::result_t                result
);
  import scrc_pkg::*;

  logic                in_frame_r, in_frame_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0]   prev_r, prev_nxt;
  logic [CRC_W-1:0]    crc_r, crc_nxt;
  logic [BYTE_W-1:0]   crc_lo_r, crc_lo_nxt;

  logic [CRC_W-1:0]    crc_src;
  logic [BYTE_W-1:0]   crc_dat;
  logic [CRC_W-1:0]    crc_step;

  // one shared byte step: second sync byte on frame start, payload byte inside
  assign crc_src  = in_frame_r ? crc_r   : cfg.seed;
  assign crc_dat  = in_frame_r ? rx_byte : cfg.sync_second;
  assign crc_step = crc_byte(crc_src, crc_dat);

  always_comb begin
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    prev_nxt     = prev_r;
    crc_nxt      = crc_r;
    crc_lo_nxt   = crc_lo_r;
    result       = '0;
    if (!in_frame_r) begin
      if (rx_byte == cfg.sync_second && prev_r == cfg.sync_first) begin
        in_frame_nxt = 1'b1;
        count_nxt    = '0;
        crc_nxt      = crc_step;
      end
      prev_nxt = rx_byte;
    end else if (count_r < PAYLOAD_COUNT) begin
      result.payload_valid = 1'b1;
      result.payload_byte  = rx_byte;
      result.payload_index = count_r;
      crc_nxt              = crc_step;
      count_nxt            = count_r + 1'b1;
    end else if (count_r == PAYLOAD_COUNT) begin
      crc_lo_nxt = rx_byte;
      count_nxt  = count_r + 1'b1;
    end else begin
      // crc high byte closes the frame
      result.frame_end = 1'b1;
      result.crc_ok    = ({rx_byte, crc_lo_r} == crc_r);
      in_frame_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      count_r    <= '0;
      prev_r     <= '0;
      crc_r      <= CRC_INIT;
      crc_lo_r   <= '0;
    end else if (take) begin
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
      prev_r     <= prev_nxt;
      crc_r      <= crc_nxt;
      crc_lo_r   <= crc_lo_nxt;
    end
  end

endmodule

`default_nettype wire

### src/scrc_outbuf.sv
// scrc_outbuf: result register plus skid register between the two handshakes
// depends on scrc_pkg (result_t)
`default_nettype none

module scrc_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire scrc_pkg::result_t push_data,
  output logic                   push_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output scrc_pkg::result_t      out_data
);
  import scrc_pkg::*;

  logic    out_v_r, out_v_nxt;
  result_t out_d_r, out_d_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t skid_d_r, skid_d_nxt;
  logic    pop;

  assign pop        = out_v_r && out_ready;
  assign push_ready = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || pop) begin
      out_v_nxt = skid_v_r || push;
      if (skid_v_r) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else if (push) begin
        out_d_nxt = push_data;
      end
    end else if (push) begin
      // result register still waiting, park the new result
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule

`default_nettype wire

### src/sync_frame_crc16_checker.sv
// sync_frame_crc16_checker: sync word deframer with crc-16/ccitt-false frame check
// depends on scrc_pkg, scrc_in_if, scrc_out_if, scrc_cfg_if, scrc_deframer, scrc_outbuf
//
//  channel  | direction | per transfer
//  ---------+-----------+----------------------------------------------------
//  in_ch    | sink      | rx_byte, one received byte
//  out_ch   | source    | payload_valid, payload_byte, payload_index,
//           |           | frame_end, crc_ok; one result per received byte
//  cfg_ch   | sink      | reg_index, wr_data; 0 sync_first, 1 sync_second
//
// one byte per cycle while in_ch.ready is high; a taken byte's result is registered in the result register, or in
// the skid register while the result register waits; the byte step and frame decision sit between the state
// registers and those registers; in_ch.ready drops only when both the result register and the skid register are full
// cfg_ch is always ready; reset restores sync bytes 0xEA / 0x9B and starts hunting
`default_nettype none

module sync_frame_crc16_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  scrc_in_if.sink     in_ch,
  scrc_out_if.source  out_ch,
  scrc_cfg_if.sink    cfg_ch
);
  import scrc_pkg::*;

  logic [BYTE_W-1:0] sync_first_r, sync_first_nxt;
  logic [BYTE_W-1:0] sync_second_r, sync_second_nxt;
  logic [CRC_W-1:0]  seed_r, seed_nxt;

  sync_cfg_t sync_cfg;
  result_t   step_result;
  result_t   out_result;
  logic      take;
  logic      in_ready;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    seed_nxt        = seed_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_SYNC_FIRST: begin
          sync_first_nxt = cfg_ch.wr_data;
          seed_nxt       = crc_byte(CRC_INIT, cfg_ch.wr_data);
        end
        REG_SYNC_SECOND: begin
          sync_second_nxt = cfg_ch.wr_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RESET;
      sync_second_r <= SYNC_SECOND_RESET;
      seed_r        <= SEED_RESET;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      seed_r        <= seed_nxt;
    end
  end

  assign sync_cfg.sync_first  = sync_first_r;
  assign sync_cfg.sync_second = sync_second_r;
  assign sync_cfg.seed        = seed_r;

  assign in_ch.ready = in_ready;
  assign take        = in_ch.valid && in_ready;

  scrc_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_ch.rx_byte),
    .cfg     (sync_cfg),
    .result  (step_result)
  );

  scrc_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_data  (step_result),
    .push_ready (in_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_result)
  );

  assign out_ch.payload_valid = out_result.payload_valid;
  assign out_ch.payload_byte  = out_result.payload_byte;
  assign out_ch.payload_index = out_result.payload_index;
  assign out_ch.frame_end     = out_result.frame_end;
  assign out_ch.crc_ok        = out_result.crc_ok;

endmodule

`default_nettype wire

### src/scrc_checker.sv
// scrc_checker: port-level assertions for sync_frame_crc16_checker, attached by bind
// depends on sync_frame_crc16_checker and its channel interfaces
`default_nettype none

module scrc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       payload_valid,
  input wire logic [7:0] payload_byte,
  input wire logic [6:0] payload_index,
  input wire logic       frame_end,
  input wire logic       crc_ok
);

  // a payload result never closes a frame
  a_payload_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && payload_valid |-> !frame_end)
    else $error("payload result marked as frame end");

  // crc_ok only on the closing byte
  a_ok_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && crc_ok |-> frame_end)
    else $error("crc_ok without frame_end");

  // non-payload results carry zero byte and index
  a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 7'd0)
    else $error("non-payload result with nonzero byte or index");

  // a stalled result holds until its transfer
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(payload_valid) &&
      $stable(payload_byte) && $stable(payload_index) && $stable(frame_end) &&
      $stable(crc_ok))
    else $error("stalled result changed");

endmodule

bind sync_frame_crc16_checker scrc_checker u_scrc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_valid (out_ch.payload_valid),
  .payload_byte  (out_ch.payload_byte),
  .payload_index (out_ch.payload_index),
  .frame_end     (out_ch.frame_end),
  .crc_ok        (out_ch.crc_ok)
);

`default_nettype wire

### sim/sync_frame_crc16_checker_test.sv
// sync_frame_crc16_checker_test: self-checking bench for the sync word deframer and crc-16 check
// depends on scrc_pkg, scrc_in_if, scrc_out_if, scrc_cfg_if and sync_frame_crc16_checker
// streams hunt noise and frames through the block and checks every per-byte report
`default_nettype none

module sync_frame_crc16_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import scrc_pkg::*;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AFTER     = 150;
  localparam int MAX_REPORTS    = 10;

  // indexes past the two sync registers, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk;
  logic rst_n;

  scrc_in_if  in_ch();
  scrc_out_if out_ch();
  scrc_cfg_if cfg_ch();

  sync_frame_crc16_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // stimulus bytes not yet transferred, and reports still owed by the block
  logic [BYTE_W-1:0] rx_stream[$];
  result_t           frame_reports[$];

  // shadow of the block: sync registers and deframer state
  logic [BYTE_W-1:0]  shadow_first;
  logic [BYTE_W-1:0]  shadow_second;
  logic               framing;
  logic [COUNT_W-1:0] frame_pos;
  logic [BYTE_W-1:0]  last_hunt_byte;
  logic [CRC_W-1:0]   frame_crc;
  logic [BYTE_W-1:0]  crc_low_seen;

  // sync bytes the stimulus builds frames with
  logic [BYTE_W-1:0] gen_first;
  logic [BYTE_W-1:0] gen_second;

  int  mismatch_count;
  int  bytes_taken;
  int  idle_odds;
  int  send_gap;
  int  recv_gap;
  logic byte_moved;
  logic long_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // msb-first crc-16, polynomial 0x1021, one bit at a time
  function automatic logic [CRC_W-1:0] crc_shift(input logic [CRC_W-1:0] c,
                                                 input logic [BYTE_W-1:0] d);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ d[i];
      c = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    r = '0;
    if (!framing) begin
      if (b == shadow_second && last_hunt_byte == shadow_first) begin
        framing   = 1'b1;
        frame_pos = '0;
        frame_crc = crc_shift(crc_shift(CRC_INIT, shadow_first), shadow_second);
      end
      last_hunt_byte = b;
    end else if (frame_pos < PAYLOAD_COUNT) begin
      r.payload_valid = 1'b1;
      r.payload_byte  = b;
      r.payload_index = frame_pos;
      frame_crc = crc_shift(frame_crc, b);
      frame_pos = frame_pos + 1'b1;
    end else if (frame_pos == PAYLOAD_COUNT) begin
      crc_low_seen = b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      // crc high byte, also anything past the expected count
      r.frame_end = 1'b1;
      r.crc_ok    = ({b, crc_low_seen} == frame_crc);
      framing = 1'b0;
    end
    return r;
  endfunction

  // checker and predictor share one clocked process
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      shadow_first   = SYNC_FIRST_RESET;
      shadow_second  = SYNC_SECOND_RESET;
      framing        = 1'b0;
      frame_pos      = '0;
      last_hunt_byte = '0;
      frame_crc      = CRC_INIT;
      crc_low_seen   = '0;
      byte_moved    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.payload_valid = out_ch.payload_valid;
        seen.payload_byte  = out_ch.payload_byte;
        seen.payload_index = out_ch.payload_index;
        seen.frame_end     = out_ch.frame_end;
        seen.crc_ok        = out_ch.crc_ok;
        if (frame_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result pv=%0b byte=%02h idx=%0d end=%0b ok=%0b",
                     seen.payload_valid, seen.payload_byte, seen.payload_index,
                     seen.frame_end, seen.crc_ok);
        end else begin
          want = frame_reports.pop_front();
          if (seen.payload_valid !== want.payload_valid ||
              seen.payload_byte  !== want.payload_byte  ||
              seen.payload_index !== want.payload_index ||
              seen.frame_end     !== want.frame_end     ||
              seen.crc_ok        !== want.crc_ok) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $write("mismatch expected pv=%0b byte=%02h idx=%0d end=%0b ok=%0b",
                     want.payload_valid, want.payload_byte, want.payload_index,
                     want.frame_end, want.crc_ok);
              $display(", got pv=%0b byte=%02h idx=%0d end=%0b ok=%0b",
                       seen.payload_valid, seen.payload_byte, seen.payload_index,
                       seen.frame_end, seen.crc_ok);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.reg_index == REG_SYNC_FIRST)
          shadow_first = cfg_ch.wr_data;
        else if (cfg_ch.reg_index == REG_SYNC_SECOND)
          shadow_second = cfg_ch.wr_data;
      end
      if (in_ch.valid && in_ch.ready) begin
        frame_reports.push_back(deframe_byte(in_ch.rx_byte));
        bytes_taken++;
      end
      byte_moved <= in_ch.valid && in_ch.ready;
    end
  end

  // byte driver: holds a byte until its transfer, random gaps in between
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (byte_moved)
        void'(rx_stream.pop_front());
      if (in_ch.valid && !byte_moved) begin
        // keep offering the same byte
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (rx_stream.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
        send_gap = $urandom_range(17, 1) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= rx_stream[0];
      end
    end
  end

  // result sink with random stall bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0) begin
      recv_gap = $urandom_range(17, 1) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one long receiver stall while bytes keep coming, so the input backs up
  initial begin
    long_hold = 1'b0;
    wait (bytes_taken >= HOLD_AFTER);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_SYNC_FIRST)
      gen_first = data;
    else if (idx == REG_SYNC_SECOND)
      gen_second = data;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (rx_stream.size() != 0 || frame_reports.size() != 0 || in_ch.valid);
  endtask

  // sync_len 2 sends both sync bytes, 1 only the second
  task automatic queue_frame(input int sync_len, input bit edge_payload, input bit bad_crc);
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] b;
    crc = crc_shift(crc_shift(CRC_INIT, gen_first), gen_second);
    if (sync_len == 2)
      rx_stream.push_back(gen_first);
    rx_stream.push_back(gen_second);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (edge_payload && (i == 0 || i == PAYLOAD_BYTES - 2))
        b = 8'h00;
      else if (edge_payload && (i == 1 || i == PAYLOAD_BYTES - 1))
        b = 8'hFF;
      else if ($urandom_range(7) == 0)
        b = $urandom_range(1) ? gen_first : gen_second;   // sync look-alikes in payload
      else
        b = 8'($urandom);
      crc = crc_shift(crc, b);
      rx_stream.push_back(b);
    end
    if (bad_crc)
      crc = crc ^ (16'd1 << $urandom_range(CRC_W - 1));
    rx_stream.push_back(crc[7:0]);
    rx_stream.push_back(crc[15:8]);
  endtask

  // hunt noise, with lone first sync bytes that lead nowhere
  task automatic queue_noise(input int count);
    for (int i = 0; i < count; i++)
      rx_stream.push_back($urandom_range(3) == 0 ? gen_first : 8'($urandom));
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.rx_byte    = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_SYNC_FIRST;
    cfg_ch.wr_data   = '0;
    mismatch_count   = 0;
    bytes_taken      = 0;
    send_gap         = 0;
    recv_gap         = 0;
    idle_odds        = 4;
    gen_first        = SYNC_FIRST_RESET;
    gen_second       = SYNC_SECOND_RESET;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // hunting corner cases with the reset sync pair, then a pair preceded by a repeat
    rx_stream.push_back(8'h00);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h80);
    rx_stream.push_back(8'h01);
    rx_stream.push_back(8'h7F);
    rx_stream.push_back(gen_second);
    rx_stream.push_back(gen_first);
    rx_stream.push_back(8'h00);
    rx_stream.push_back(gen_first);
    queue_frame(2, 1'b1, 1'b0);
    // previous byte still holds the second sync byte, so this must not lock
    rx_stream.push_back(gen_second);
    rx_stream.push_back(8'h00);
    queue_frame(2, 1'b0, 1'b1);
    queue_noise(8);
    wait_drained();

    write_reg(REG_SYNC_FIRST, 8'h00);
    write_reg(REG_SYNC_SECOND, 8'hFF);
    idle_odds = 6;
    queue_noise(6);
    queue_frame(2, 1'b1, 1'b0);
    queue_frame(2, 1'b0, 1'b1);
    wait_drained();

    write_reg(REG_SYNC_FIRST, 8'hFF);
    write_reg(REG_SYNC_SECOND, 8'h00);
    write_reg(REG_SPARE_A, 8'($urandom));
    write_reg(REG_SPARE_B, 8'($urandom));
    idle_odds = 2;
    queue_frame(2, 1'b0, $urandom_range(3) == 0);
    queue_noise(5);
    wait_drained();

    // equal sync bytes: one byte right after a frame starts the next one
    write_reg(REG_SYNC_FIRST, 8'h77);
    write_reg(REG_SYNC_SECOND, 8'h77);
    idle_odds = 5;
    queue_frame(2, 1'b0, 1'b0);
    queue_frame(1, 1'b0, $urandom_range(3) == 0);
    queue_noise(4);
    wait_drained();

    // closing stretch without idling on either side
    write_reg(REG_SYNC_FIRST, 8'($urandom));
    write_reg(REG_SYNC_SECOND, 8'($urandom));
    idle_odds = 0;
    send_gap  = 0;
    recv_gap  = 0;
    queue_noise(4);
    queue_frame(2, 1'b0, $urandom_range(3) == 0);
    wait_drained();
    repeat (4) @(posedge clk);

    if (frame_reports.size() != 0)
      mismatch_count++;
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

### sync_frame_crc16_checker.f
src/scrc_pkg.sv
src/scrc_in_if.sv
src/scrc_out_if.sv
src/scrc_cfg_if.sv
src/scrc_deframer.sv
src/scrc_outbuf.sv
src/sync_frame_crc16_checker.sv
src/scrc_checker.sv
sim/sync_frame_crc16_checker_test.sv
